// ===== src/scsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the selective cross smoothing filter.
// No dependencies; used by scsf_out_queue and selective_cross_smoothing_filter.
package scsf_pkg;

  localparam int ChanBits = 16;
  localparam int SumW     = 19;   // five channel values
  localparam int ColOutW  = 11;
  localparam int RowOutW  = 12;
  localparam int QDepth   = 16;
  localparam int QAw      = 4;
  localparam int DivShift = 21;
  localparam logic [19:0] Recip3 = 20'd699051;  // ceil(2^21 / 3)
  localparam logic [19:0] Recip5 = 20'd419431;  // ceil(2^21 / 5)

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef logic [2:0][ChanBits-1:0] pix_t;

  typedef struct packed {
    logic [2:0][SumW-1:0] sum;
    logic [2:0]           cnt;
  } acc_t;

  typedef struct packed {
    pix_t               pix;
    logic [ColOutW-1:0] col;
    logic [RowOutW-1:0] row;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [QAw:0] level;
  } q_stat_t;

  // per-result control carried from the accept stage
  typedef struct packed {
    logic e1;     // upper-row pixel emitted
    logic e2;     // left pixel of last row emitted
    logic e3;     // right edge pixel of last row emitted
    logic ok_l;
    logic ok_r;
    logic ok_u;
    logic ok_l2;
  } ctl_t;

  // neighbor order: left, right, up, down
  function automatic acc_t gather(pix_t ctr, pix_t [3:0] nb, logic [3:0] ok,
                                  logic [17:0] thr);
    acc_t               a;
    logic [17:0]        sc;
    logic [17:0]        sn;
    logic signed [19:0] d;
    sc = 18'(ctr[0]) + 18'(ctr[1]) + 18'(ctr[2]);
    a.cnt = 3'd1;
    for (int k = 0; k < 3; k++) a.sum[k] = SumW'(ctr[k]);
    for (int i = 0; i < 4; i++) begin
      sn = 18'(nb[i][0]) + 18'(nb[i][1]) + 18'(nb[i][2]);
      d  = $signed({2'b00, sc}) - $signed({2'b00, sn});
      if (ok[i] && (d > $signed({2'b00, thr}))) begin
        for (int k = 0; k < 3; k++) a.sum[k] = a.sum[k] + SumW'(nb[i][k]);
        a.cnt = a.cnt + 3'd1;
      end
    end
    return a;
  endfunction

  // truncated mean for 3..5 terms, centre passes through otherwise
  function automatic logic [ChanBits-1:0] mean(logic [SumW-1:0] s, logic [2:0] n,
                                               logic [ChanBits-1:0] ctr);
    logic [SumW+19:0] prod;
    logic [19:0]      k;
    k    = (n == 3'd5) ? Recip5 : Recip3;
    prod = (SumW+20)'(s) * (SumW+20)'(k);
    if (n < 3'd3) return ctr;
    else if (n == 3'd4) return s[ChanBits+1:2];
    else return prod[DivShift+ChanBits-1:DivShift];
  endfunction

endpackage

// ===== src/scsf_out_queue.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle, hands them out one per transaction.
// Depends on scsf_pkg.
module scsf_out_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0]            wr_en,
  input  scsf_pkg::res_t [2:0]  wr_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output scsf_pkg::res_t        out_data,
  output scsf_pkg::q_stat_t     stat
);
  import scsf_pkg::*;

  res_t           q_mem [QDepth];
  logic [QAw-1:0] wp_r, wp_nxt;
  logic [QAw-1:0] rp_r, rp_nxt;
  logic [QAw:0]   level_r, level_nxt;
  logic [QAw-1:0] off [3];
  logic [1:0]     n_push;
  logic           pop;

  always_comb begin
    off[0] = '0;
    off[1] = QAw'(wr_en[0]);
    off[2] = QAw'(wr_en[0]) + QAw'(wr_en[1]);
    n_push = 2'(wr_en[0]) + 2'(wr_en[1]) + 2'(wr_en[2]);
    pop    = out_valid && out_ready;
    wp_nxt = wp_r + QAw'(n_push);
    rp_nxt = rp_r + QAw'(pop);
    level_nxt = level_r + (QAw+1)'(n_push) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (wr_en[i]) q_mem[wp_r + off[i]] <= wr_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  assign out_valid  = (level_r != '0);
  assign out_data   = q_mem[rp_r];
  assign stat.level = level_r;

endmodule

// ===== src/selective_cross_smoothing_filter.sv =====
`timescale 1ns / 1ps
// Top level of the selective cross smoothing filter: APB registers, two row memories,
// neighbor window and averaging pipeline. Depends on scsf_pkg and scsf_out_queue.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  in       | sink      | in_valid/in_ready   | in_red, in_green, in_blue, in_frame_start
//  out      | source    | out_valid/out_ready | out_red/green/blue, out_column, out_row,
//           |           |                     | out_last_of_run
//  cfg      | APB slave | psel/penable/pready | paddr, pwdata, prdata (width/height/thr)
//
// One pixel per clock while in_ready is high; each row memory has one read and one write
// port per cycle, and an input transaction turns into 0 to 3 results that pass through the
// stage 1 and stage 2 registers into a 16-entry queue that drives out_valid.
// Rows other than the last give at most one result per pixel, so there the rate is one pixel
// per clock; on the last row the output port limits it to one result per clock.
// Synchronous active-low reset clears counters, held pixels, registers and the queue;
// row memories are not cleared. in_ready drops when the queue cannot take the worst case
// of the transactions in flight; out_ready low stalls only through that queue.
module selective_cross_smoothing_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [10:0] out_column,
  output logic [11:0] out_row,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scsf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [11:0] fw_r;
  logic [12:0] fh_r;
  logic [17:0] thr_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= 12'd640;
      fh_r  <= 13'd480;
      thr_r <= 18'd3277;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:     fw_r  <= pwdata[11:0];
        REG_HEIGHT:    fh_r  <= pwdata[12:0];
        REG_THRESHOLD: thr_r <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:     prdata = {20'd0, fw_r};
      REG_HEIGHT:    prdata = {19'd0, fh_r};
      REG_THRESHOLD: prdata = {14'd0, thr_r};
      default:       prdata = '0;
    endcase
  end

  // accept stage
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic [CW-1:0] col_r, col_nxt, c;
  logic [RW-1:0] row_r, row_nxt, r;
  logic [CW:0]   c1;
  logic [RW:0]   r1;
  logic          restart, acc_in, last_row;
  pix_t          cur, h0_r, h1_r, first_r;
  ctl_t          ctl;

  always_comb begin
    if (fw_r < 12'd2) w_eff = (CW+1)'(2);
    else if (32'(fw_r) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(fw_r);
    if (fh_r < 13'd2) h_eff = (RW+1)'(2);
    else if (32'(fh_r) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(fh_r);
  end

  always_comb begin
    cur      = {in_blue, in_green, in_red};
    acc_in   = in_valid && in_ready;
    restart  = in_frame_start || ({1'b0, col_r} >= w_eff) || ({1'b0, row_r} >= h_eff);
    c        = restart ? '0 : col_r;
    r        = restart ? '0 : row_r;
    c1       = {1'b0, c} + (CW+1)'(1);
    r1       = {1'b0, r} + (RW+1)'(1);
    last_row = (r1 == h_eff);
    ctl.e1    = (r != '0);
    ctl.e2    = ctl.e1 && last_row && (c != '0);
    ctl.e3    = ctl.e1 && last_row && (c1 == w_eff);
    ctl.ok_l  = (c != '0);
    ctl.ok_r  = (c1 < w_eff);
    ctl.ok_u  = (r > RW'(1));
    ctl.ok_l2 = (c > CW'(1));
    if (c1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r1 >= h_eff) ? '0 : r1[RW-1:0];
    end else begin
      col_nxt = c1[CW-1:0];
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      h0_r  <= '0;
      h1_r  <= '0;
    end else if (acc_in) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      h0_r  <= cur;
      h1_r  <= h0_r;
    end
  end

  // column 0 of the previous row comes from here, not from the row memory
  always_ff @(posedge clk) begin
    if (acc_in && (c == '0)) first_r <= cur;
  end

  // row memories: even rows in mem_a, odd rows in mem_b; read-first on a shared address
  pix_t          mem_a [MAX_WIDTH];
  pix_t          mem_b [MAX_WIDTH];
  pix_t          a_q, b_q;
  logic [CW-1:0] addr_a, addr_b;

  assign addr_a = r[0] ? c1[CW-1:0] : c;
  assign addr_b = r[0] ? c : c1[CW-1:0];

  always_ff @(posedge clk) begin
    if (acc_in) begin
      if (!r[0]) mem_a[c] <= cur;
      a_q <= mem_a[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      if (r[0]) mem_b[c] <= cur;
      b_q <= mem_b[addr_b];
    end
  end

  // stage 1: memory data arrives, neighbor window, join tests and sums
  logic          s1_v_r;
  ctl_t          s1_ctl_r;
  pix_t          s1_cur_r, s1_h0_r, s1_h1_r, s1_first_r;
  logic [CW-1:0] s1_c_r;
  logic [RW-1:0] s1_r_r;
  logic          s1_par_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= acc_in;
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_ctl_r   <= ctl;
      s1_cur_r   <= cur;
      s1_h0_r    <= h0_r;
      s1_h1_r    <= h1_r;
      s1_first_r <= first_r;
      s1_c_r     <= c;
      s1_r_r     <= r;
      s1_par_r   <= r[0];
    end
  end

  pix_t       win_l_r, win_c_r;
  pix_t       prev_d, up_d, w_left, w_ctr;
  pix_t [3:0] nb1, nb2, nb3;
  acc_t       acc1, acc2, acc3;

  always_comb begin
    prev_d = s1_par_r ? a_q : b_q;
    up_d   = s1_par_r ? b_q : a_q;
    w_left = win_l_r;
    w_ctr  = (s1_c_r == '0) ? s1_first_r : win_c_r;
    nb1 = {s1_cur_r, up_d, prev_d, w_left};
    nb2 = {s1_cur_r, w_left, s1_cur_r, s1_h1_r};
    nb3 = {s1_cur_r, w_ctr, s1_cur_r, s1_h0_r};
    acc1 = gather(w_ctr, nb1,
                  {1'b1, s1_ctl_r.ok_u, s1_ctl_r.ok_r, s1_ctl_r.ok_l}, thr_r);
    acc2 = gather(s1_h0_r, nb2, {1'b0, 1'b1, 1'b1, s1_ctl_r.ok_l2}, thr_r);
    acc3 = gather(s1_cur_r, nb3, 4'b0101, thr_r);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_l_r <= w_ctr;
      win_c_r <= prev_d;
    end
  end

  // stage 2: sums registered, mean taken on the way into the queue
  logic                     s2_v_r;
  ctl_t                     s2_ctl_r;
  acc_t [2:0]               s2_acc_r;
  pix_t [2:0]               s2_ctr_r;
  logic [2:0][ColOutW-1:0]  s2_col_r;
  logic [2:0][RowOutW-1:0]  s2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_ctl_r    <= s1_ctl_r;
      s2_acc_r    <= {acc3, acc2, acc1};
      s2_ctr_r    <= {s1_cur_r, s1_h0_r, w_ctr};
      s2_col_r[0] <= ColOutW'(s1_c_r);
      s2_row_r[0] <= RowOutW'(s1_r_r - RW'(1));
      s2_col_r[1] <= ColOutW'(s1_c_r - CW'(1));
      s2_row_r[1] <= RowOutW'(s1_r_r);
      s2_col_r[2] <= ColOutW'(s1_c_r);
      s2_row_r[2] <= RowOutW'(s1_r_r);
    end
  end

  logic [2:0]     wr_en;
  res_t [2:0]     wr_data;
  res_t           head;
  q_stat_t        q_stat;
  logic [QAw+1:0] commit;

  always_comb begin
    wr_en = s2_v_r ? {s2_ctl_r.e3, s2_ctl_r.e2, s2_ctl_r.e1} : 3'b000;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        wr_data[i].pix[k] = mean(s2_acc_r[i].sum[k], s2_acc_r[i].cnt, s2_ctr_r[i][k]);
      end
      wr_data[i].col = s2_col_r[i];
      wr_data[i].row = s2_row_r[i];
    end
    wr_data[0].last = !s2_ctl_r.e2 && !s2_ctl_r.e3;
    wr_data[1].last = !s2_ctl_r.e3;
    wr_data[2].last = 1'b1;
  end

  scsf_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head),
    .stat      (q_stat)
  );

  // room for three results from each transaction in flight plus the new one
  always_comb begin
    commit   = (QAw+2)'(q_stat.level) + (s1_v_r ? (QAw+2)'(3) : '0)
             + (s2_v_r ? (QAw+2)'(3) : '0);
    in_ready = (commit <= (QAw+2)'(QDepth - 3));
  end

  assign out_red         = head.pix[0];
  assign out_green       = head.pix[1];
  assign out_blue        = head.pix[2];
  assign out_column      = head.col;
  assign out_row         = head.row;
  assign out_last_of_run = head.last;

  // checks
  a_pipe_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("stage 1 transaction lost");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= (QAw+1)'(QDepth))
    else $error("result queue overflow");

  a_row0_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_ctl_r.e1) |-> (!s2_ctl_r.e2 && !s2_ctl_r.e3))
    else $error("last-row result without upper-row result");

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (q_stat.level <= (QAw+1)'(QDepth - 3)))
    else $error("queue too full after accept");

endmodule
